// ----- src/prcs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants for the pixel colour range search block.
package prcs_pkg;

    localparam int RANGE_CAP       = 8;
    localparam int MAX_RANGES_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int SLOT_W   = 3;
    localparam int COLOR_W  = 24;
    localparam int PIXEL_W  = 32;
    localparam int POS_W    = 24;
    localparam int COUNT_W  = 32;
    localparam int RCOUNT_W = 4;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    typedef enum logic {
        ACT_WRITE_RANGE = 1'b0,
        ACT_TEST_PIXEL  = 1'b1
    } action_t;

    typedef enum logic {
        KIND_MATCH = 1'b0,
        KIND_TOTAL = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH_LIMIT = 1'b0,
        CFG_RANGE_COUNT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [RANGE_CAP-1:0] mask;
        logic [POS_W-1:0]     position;
        logic                 last;
    } job_t;

endpackage

// ----- src/prcs_front.sv -----
`timescale 1ns / 1ps
// Front end: range bound storage, parallel colour compare and job build.
module prcs_front #(
    parameter int MAX_RANGES = prcs_pkg::MAX_RANGES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [prcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [prcs_pkg::RCOUNT_W-1:0]   cfg_count,
    input  logic                            accept,
    input  logic                            action,
    input  logic [prcs_pkg::SLOT_W-1:0]     range_slot,
    input  logic [prcs_pkg::COLOR_W-1:0]    range_high,
    input  logic [prcs_pkg::COLOR_W-1:0]    range_low,
    input  logic [prcs_pkg::PIXEL_W-1:0]    pixel_color,
    input  logic [prcs_pkg::POS_W-1:0]      pixel_position,
    input  logic                            last_pixel,
    output prcs_pkg::job_t                  job,
    output logic                            job_valid
);
    import prcs_pkg::*;

    localparam int NUM_SLOTS = (MAX_RANGES < RANGE_CAP) ? MAX_RANGES : RANGE_CAP;

    logic [COLOR_W-1:0]  high_bound_reg [NUM_SLOTS];
    logic [COLOR_W-1:0]  low_bound_reg  [NUM_SLOTS];
    logic [RCOUNT_W-1:0] range_count_reg;
    logic [RCOUNT_W-1:0] range_count_next;
    logic [NUM_SLOTS-1:0] hit;
    logic                write_en;

    function automatic logic chan_in(logic [7:0] p, logic [7:0] h, logic [7:0] l);
        return (p <= h) && (p >= l);
    endfunction

    assign write_en = accept && (action == ACT_WRITE_RANGE);

    always_comb
    begin
        range_count_next = range_count_reg;
        if (cfg_wen && (cfg_index == CFG_RANGE_COUNT))
        begin
            range_count_next = cfg_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_count_reg <= '0;
        end
        else
        begin
            range_count_reg <= range_count_next;
        end
    end

    for (genvar r = 0; r < NUM_SLOTS; r++)
    begin : g_lane
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                high_bound_reg[r] <= '0;
                low_bound_reg[r]  <= '0;
            end
            else if (write_en && (range_slot == SLOT_W'(r)))
            begin
                high_bound_reg[r] <= range_high;
                low_bound_reg[r]  <= range_low;
            end
        end

        assign hit[r] = (RCOUNT_W'(r) < range_count_reg)
            && chan_in(pixel_color[23:16], high_bound_reg[r][23:16], low_bound_reg[r][23:16])
            && chan_in(pixel_color[15:8],  high_bound_reg[r][15:8],  low_bound_reg[r][15:8])
            && chan_in(pixel_color[7:0],   high_bound_reg[r][7:0],   low_bound_reg[r][7:0]);
    end

    assign job.mask     = RANGE_CAP'(hit);
    assign job.position = pixel_position;
    assign job.last     = last_pixel;
    assign job_valid    = accept && (action == ACT_TEST_PIXEL) && ((|hit) || last_pixel);

endmodule

// ----- src/prcs_fifo.sv -----
`timescale 1ns / 1ps
// Job queue between the compare front end and the result sequencer.
module prcs_fifo #(
    parameter int DEPTH = prcs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  prcs_pkg::job_t din,
    output logic           full,
    input  logic           pop,
    output prcs_pkg::job_t dout,
    output logic           empty
);
    import prcs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- src/prcs_back.sv -----
`timescale 1ns / 1ps
// Back end: walks each job's match mask, keeps the running count, drives the result beat.
module prcs_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [prcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [prcs_pkg::CFG_W-1:0]      cfg_wdata,
    input  prcs_pkg::job_t                  job,
    input  logic                            job_empty,
    output logic                            job_pop,
    input  logic                            pop,
    output logic                            empty,
    output logic                            kind,
    output logic [prcs_pkg::POS_W-1:0]      match_position,
    output logic [prcs_pkg::SLOT_W-1:0]     match_range,
    output logic                            match_kept,
    output logic [prcs_pkg::COUNT_W-1:0]    match_total,
    output logic                            last
);
    import prcs_pkg::*;

    logic [RANGE_CAP-1:0] done_reg, done_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [COUNT_W-1:0]   limit_reg, limit_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 kind_reg, kind_next;
    logic [POS_W-1:0]     position_reg, position_next;
    logic [SLOT_W-1:0]    range_reg, range_next;
    logic                 kept_reg, kept_next;
    logic [COUNT_W-1:0]   total_reg, total_next;
    logic                 last_reg, last_next;

    logic [RANGE_CAP-1:0] remaining, lowest;
    logic [SLOT_W-1:0]    low_idx;
    logic [COUNT_W-1:0]   count_inc;
    logic                 single, summary, step;

    assign step      = !job_empty && (!out_valid_reg || pop);
    assign remaining = job.mask & ~done_reg;
    assign lowest    = remaining & (~remaining + 1'b1);
    assign single    = ((remaining & (remaining - 1'b1)) == '0);
    assign summary   = (remaining == '0);
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;

    always_comb
    begin
        low_idx = '0;
        for (int i = RANGE_CAP - 1; i >= 0; i--)
        begin
            if (lowest[i])
            begin
                low_idx = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        limit_next = limit_reg;
        if (cfg_wen && (cfg_index == CFG_MATCH_LIMIT))
        begin
            limit_next = cfg_wdata;
        end
    end

    always_comb
    begin
        done_next      = done_reg;
        count_next     = count_reg;
        job_pop        = 1'b0;
        out_valid_next = out_valid_reg && !pop;
        kind_next      = kind_reg;
        position_next  = position_reg;
        range_next     = range_reg;
        kept_next      = kept_reg;
        total_next     = total_reg;
        last_next      = last_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
            position_next  = job.position;
            if (summary)
            begin
                kind_next  = KIND_TOTAL;
                range_next = '0;
                kept_next  = 1'b0;
                total_next = count_reg;
                last_next  = 1'b1;
                count_next = '0;
                done_next  = '0;
                job_pop    = 1'b1;
            end
            else
            begin
                kind_next  = KIND_MATCH;
                range_next = low_idx;
                kept_next  = (count_reg < limit_reg);
                total_next = count_inc;
                count_next = count_inc;
                last_next  = single && !job.last;
                if (single && !job.last)
                begin
                    done_next = '0;
                    job_pop   = 1'b1;
                end
                else
                begin
                    done_next = done_reg | lowest;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            count_reg     <= '0;
            limit_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            count_reg     <= count_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        position_reg <= position_next;
        range_reg    <= range_next;
        kept_reg     <= kept_next;
        total_reg    <= total_next;
        last_reg     <= last_next;
    end

    assign empty          = !out_valid_reg;
    assign kind           = kind_reg;
    assign match_position = position_reg;
    assign match_range    = range_reg;
    assign match_kept     = kept_reg;
    assign match_total    = total_reg;
    assign last           = last_reg;

endmodule

// ----- src/pixel_color_range_search.sv -----
`timescale 1ns / 1ps
// A result is registered in the job queue and then in the back end's output register.
// While full is low one item per cycle enters; while pop keeps up the result side emits one
// beat per cycle; a pixel gives a beat per matching range, plus a total beat if last.
// The job queue between compare and sequencer absorbs match bursts; full rises when it fills.
// Reset clears the range bounds, both config registers, the running count and the job queue.
module pixel_color_range_search #(
    parameter int MAX_RANGES  = prcs_pkg::MAX_RANGES_DEF,
    parameter int QUEUE_DEPTH = prcs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [prcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [prcs_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            push,
    output logic                            full,
    input  logic                            action,
    input  logic [prcs_pkg::SLOT_W-1:0]     range_slot,
    input  logic [prcs_pkg::COLOR_W-1:0]    range_high,
    input  logic [prcs_pkg::COLOR_W-1:0]    range_low,
    input  logic [prcs_pkg::PIXEL_W-1:0]    pixel_color,
    input  logic [prcs_pkg::POS_W-1:0]      pixel_position,
    input  logic                            last_pixel,
    output logic                            empty,
    input  logic                            pop,
    output logic                            kind,
    output logic [prcs_pkg::POS_W-1:0]      match_position,
    output logic [prcs_pkg::SLOT_W-1:0]     match_range,
    output logic                            match_kept,
    output logic [prcs_pkg::COUNT_W-1:0]    match_total,
    output logic                            last
);
    import prcs_pkg::*;

    job_t front_job, head_job;
    logic q_push, q_full, q_pop, q_empty, accept;

    assign accept = push && !q_full;
    assign full   = q_full;

    prcs_front #(
        .MAX_RANGES (MAX_RANGES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wen        (cfg_wen),
        .cfg_index      (cfg_index),
        .cfg_count      (cfg_wdata[RCOUNT_W-1:0]),
        .accept         (accept),
        .action         (action),
        .range_slot     (range_slot),
        .range_high     (range_high),
        .range_low      (range_low),
        .pixel_color    (pixel_color),
        .pixel_position (pixel_position),
        .last_pixel     (last_pixel),
        .job            (front_job),
        .job_valid      (q_push)
    );

    prcs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (front_job),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (head_job),
        .empty (q_empty)
    );

    prcs_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wen        (cfg_wen),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .job            (head_job),
        .job_empty      (q_empty),
        .job_pop        (q_pop),
        .pop            (pop),
        .empty          (empty),
        .kind           (kind),
        .match_position (match_position),
        .match_range    (match_range),
        .match_kept     (match_kept),
        .match_total    (match_total),
        .last           (last)
    );

    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("job pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (kind == KIND_TOTAL)) |-> last)
        else $error("total beat without last");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (kind == KIND_MATCH)) |-> (match_total != '0))
        else $error("match beat with zero running count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result beat dropped while stalled");

endmodule
